/* src/upf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package upf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W_VAL     = 31;
    localparam int W_SAT     = 17;
    localparam int W_DEN     = W_SAT + 1;
    localparam int W_NUM     = W_VAL + W_DEN;
    localparam int W_PROD    = 2 * W_VAL;
    localparam int DIV_STEPS = W_VAL;

    localparam int LAT_TOP   = 2;
    localparam int LAT_WMEAN = DIV_STEPS + 3;
    localparam int LAT_POT   = 5;
    localparam int LAT_FLUX  = 4;
    localparam int LAT_TOTAL = LAT_TOP + LAT_WMEAN + LAT_POT + LAT_FLUX;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index REG_TIME_STEP      = 2'd0;
    localparam t_cfg_index REG_GRAVITY_FACTOR = 2'd1;
    localparam t_cfg_index REG_UNIT_SCALE     = 2'd2;

    typedef struct packed {
        logic [1:0]          presence;
        logic [W_VAL-1:0]    density_begin;
        logic [W_VAL-1:0]    density_end;
        logic [W_SAT-1:0]    sat_begin;
        logic [W_SAT-1:0]    sat_end;
        logic signed [31:0]  pressure_begin;
        logic signed [31:0]  pressure_end;
        logic signed [31:0]  depth_begin;
        logic signed [31:0]  depth_end;
        logic [W_VAL-1:0]    mobility_begin;
        logic [W_VAL-1:0]    mobility_end;
        logic [W_VAL-1:0]    transmissibility;
    } t_in_item;

    typedef struct packed {
        logic                upwind_is_end;
        logic [W_VAL-1:0]    mixed_density;
        logic signed [31:0]  phase_flux;
        logic                flux_valid;
        logic                overflow;
    } t_out_item;

    typedef struct packed {
        logic [1:0]          presence;
        logic signed [31:0]  pressure_begin;
        logic signed [31:0]  pressure_end;
        logic signed [31:0]  depth_begin;
        logic signed [31:0]  depth_end;
        logic [W_VAL-1:0]    mobility_begin;
        logic [W_VAL-1:0]    mobility_end;
        logic [W_VAL-1:0]    coef;
        logic                coef_ovf;
    } t_ctx;

    typedef struct packed {
        logic                none;
        logic                live;
        logic                up_end;
        logic [W_VAL-1:0]    rho;
        logic signed [33:0]  dp;
        logic [W_VAL-1:0]    mob_up;
        logic [W_VAL-1:0]    coef;
        logic                coef_ovf;
        logic                ovf;
    } t_pot;

    // unsigned product shifted down, clamped to 31 bits; msb is the overflow flag
    function automatic logic [W_VAL:0] sat_u31(input logic [W_PROD-1:0] p);
        logic ovf;
        logic [W_VAL-1:0] val;
        ovf = |p[W_PROD-1:FRAC_BITS+W_VAL];
        val = ovf ? {W_VAL{1'b1}} : p[FRAC_BITS+W_VAL-1:FRAC_BITS];
        return {ovf, val};
    endfunction

    // signed product, floor shift, clamped to 32 bits; msb is the overflow flag
    function automatic logic [32:0] sat_s32_shr(input logic signed [63:0] p);
        logic signed [63:0] s;
        logic [32:0] hi;
        logic ok;
        logic [31:0] val;
        s = p >>> FRAC_BITS;
        hi = s[63:31];
        ok = (&hi) | (~|hi);
        val = ok ? s[31:0] : (s[63] ? 32'h8000_0000 : 32'h7FFF_FFFF);
        return {~ok, val};
    endfunction

endpackage
`default_nettype wire

/* src/upwind_phase_flux.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake                 payload
// item      in         start high, busy low      i_item (t_in_item)
// result    out        o_done for one cycle      o_result (t_out_item)
// config    in         i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// one item enters every cycle; busy stays low
// result comes out after the 31-step pipelined divider of the weighted
// density and the multiplier stages
// reset is synchronous, clears the valid bits and loads the config register defaults
// the receiver cannot stall, so no stage ever holds
module upwind_phase_flux (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire upf_pkg::t_in_item         i_item,
    output logic                           o_done,
    output upf_pkg::t_out_item             o_result,
    input  wire logic                      i_cfg_wr_en,
    input  wire upf_pkg::t_cfg_index       i_cfg_index,
    input  wire logic [upf_pkg::W_VAL-1:0] i_cfg_data
);

    localparam int WV = upf_pkg::W_VAL;
    localparam int WP = upf_pkg::W_PROD;

    logic [WV-1:0] r_time_step, r_gravity, r_unit_scale;
    logic [WV-1:0] r_a;
    logic          r_a_ovf;
    logic [WV:0]   asat;

    assign busy = 1'b0;
    assign asat = upf_pkg::sat_u31(WP'(r_time_step) * WP'(r_unit_scale));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step  <= WV'(65536);
            r_gravity    <= '0;
            r_unit_scale <= WV'(65536);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                upf_pkg::REG_TIME_STEP:      r_time_step  <= i_cfg_data;
                upf_pkg::REG_GRAVITY_FACTOR: r_gravity    <= i_cfg_data;
                upf_pkg::REG_UNIT_SCALE:     r_unit_scale <= i_cfg_data;
                default: ;
            endcase
        end
        r_a     <= asat[WV-1:0];
        r_a_ovf <= asat[WV];
    end

    logic              r_v1, r_v2;
    upf_pkg::t_in_item r_item1, r_item2;
    logic [WP-1:0]     r_bprod;
    logic              r_a_ovf2;
    logic [WV:0]       bsat;
    upf_pkg::t_ctx     ctx;

    always_comb begin
        bsat             = upf_pkg::sat_u31(r_bprod);
        ctx.presence       = r_item2.presence;
        ctx.pressure_begin = r_item2.pressure_begin;
        ctx.pressure_end   = r_item2.pressure_end;
        ctx.depth_begin    = r_item2.depth_begin;
        ctx.depth_end      = r_item2.depth_end;
        ctx.mobility_begin = r_item2.mobility_begin;
        ctx.mobility_end   = r_item2.mobility_end;
        ctx.coef           = bsat[WV-1:0];
        ctx.coef_ovf       = r_a_ovf2 | bsat[WV];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
            r_v2 <= r_v1;
        end
        r_item1  <= i_item;
        r_item2  <= r_item1;
        r_bprod  <= WP'(r_a) * WP'(r_item1.transmissibility);
        r_a_ovf2 <= r_a_ovf;
    end

    logic          wm_valid;
    logic [WV-1:0] wm_rho;
    upf_pkg::t_ctx wm_ctx;
    logic          pot_valid;
    upf_pkg::t_pot pot;

    upf_wmean u_wmean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_item  (r_item2),
        .i_ctx   (ctx),
        .o_valid (wm_valid),
        .o_rho   (wm_rho),
        .o_ctx   (wm_ctx)
    );

    upf_potential u_potential (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (wm_valid),
        .i_rho     (wm_rho),
        .i_ctx     (wm_ctx),
        .i_gravity (r_gravity),
        .o_valid   (pot_valid),
        .o_pot     (pot)
    );

    upf_flux u_flux (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pot_valid),
        .i_pot   (pot),
        .o_valid (o_done),
        .o_item  (o_result)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, upf_pkg::LAT_TOTAL))
        else $error("result without a matching item");

    a_flux_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.flux_valid |-> o_result.phase_flux == '0)
        else $error("invalid flux not zero");

    a_sign_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.upwind_is_end |->
            o_result.phase_flux[31] || o_result.phase_flux == '0)
        else $error("flux sign disagrees with upwind end");

    a_sign_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.upwind_is_end |-> !o_result.phase_flux[31])
        else $error("flux sign disagrees with upwind begin");

endmodule
`default_nettype wire

/* src/upf_wmean.sv */
`timescale 1ns / 1ps
`default_nettype none
module upf_wmean (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire upf_pkg::t_in_item  i_item,
    input  wire upf_pkg::t_ctx      i_ctx,
    output logic                    o_valid,
    output logic [upf_pkg::W_VAL-1:0] o_rho,
    output upf_pkg::t_ctx           o_ctx
);

    localparam int WV = upf_pkg::W_VAL;
    localparam int WD = upf_pkg::W_DEN;
    localparam int WN = upf_pkg::W_NUM;
    localparam int NS = upf_pkg::DIV_STEPS;

    logic                r_va;
    logic [WN-2:0]       r_pb_prod;
    logic [WN-2:0]       r_pe_prod;
    logic [WD-1:0]       r_den;
    logic [WV-1:0]       r_alt;
    logic                r_use_q;
    upf_pkg::t_ctx       r_ctx_a;

    logic                both;
    logic [WD-1:0]       n_den;
    logic [WV-1:0]       n_alt;

    always_comb begin
        both  = i_item.presence[0] & i_item.presence[1];
        n_den = WD'(i_item.sat_begin) + WD'(i_item.sat_end);
        if (both) begin
            n_alt = WV'((32'(i_item.density_begin) + 32'(i_item.density_end)) >> 1);
        end else if (i_item.presence[0]) begin
            n_alt = i_item.density_begin;
        end else if (i_item.presence[1]) begin
            n_alt = i_item.density_end;
        end else begin
            n_alt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_pb_prod <= (WN-1)'(i_item.density_begin) * (WN-1)'(i_item.sat_begin);
        r_pe_prod <= (WN-1)'(i_item.density_end) * (WN-1)'(i_item.sat_end);
        r_den     <= n_den;
        r_alt     <= n_alt;
        r_use_q   <= both && (n_den != '0);
        r_ctx_a   <= i_ctx;
    end

    logic                r_dv   [0:NS];
    logic [WD-1:0]       r_rem  [0:NS];
    logic [WV-1:0]       r_low  [0:NS];
    logic [WV-1:0]       r_q    [0:NS];
    logic [WD-1:0]       r_dden [0:NS];
    logic [WV-1:0]       r_dalt [0:NS];
    logic                r_duse [0:NS];
    upf_pkg::t_ctx       r_dctx [0:NS];

    logic [WN-1:0]       num;
    assign num = WN'(r_pb_prod) + WN'(r_pe_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_va;
        end
        r_rem[0]  <= num[WN-1:WV];
        r_low[0]  <= num[WV-1:0];
        r_q[0]    <= '0;
        r_dden[0] <= r_den;
        r_dalt[0] <= r_alt;
        r_duse[0] <= r_use_q;
        r_dctx[0] <= r_ctx_a;
    end

    for (genvar k = 1; k <= NS; k++) begin : g_div
        logic [WD:0] trial;
        logic [WD:0] diff;
        logic        ge;
        always_comb begin
            trial = {r_rem[k-1], r_low[k-1][WV-1]};
            ge    = trial >= {1'b0, r_dden[k-1]};
            diff  = trial - {1'b0, r_dden[k-1]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else begin
                r_dv[k] <= r_dv[k-1];
            end
            r_rem[k]  <= ge ? diff[WD-1:0] : trial[WD-1:0];
            r_low[k]  <= r_low[k-1] << 1;
            r_q[k]    <= {r_q[k-1][WV-2:0], ge};
            r_dden[k] <= r_dden[k-1];
            r_dalt[k] <= r_dalt[k-1];
            r_duse[k] <= r_duse[k-1];
            r_dctx[k] <= r_dctx[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_dv[NS];
        end
        o_rho <= r_duse[NS] ? r_q[NS] : r_dalt[NS];
        o_ctx <= r_dctx[NS];
    end

endmodule
`default_nettype wire

/* src/upf_potential.sv */
`timescale 1ns / 1ps
`default_nettype none
module upf_potential (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire logic [upf_pkg::W_VAL-1:0] i_rho,
    input  wire upf_pkg::t_ctx             i_ctx,
    input  wire logic [upf_pkg::W_VAL-1:0] i_gravity,
    output logic                           o_valid,
    output upf_pkg::t_pot                  o_pot
);

    localparam int WV = upf_pkg::W_VAL;
    localparam int WP = upf_pkg::W_PROD;

    logic r_v1, r_v2, r_v3, r_v4;
    logic [WP-1:0]      r_gp;
    logic [WV-1:0]      r_rho1, r_rho2, r_rho3, r_rho4;
    upf_pkg::t_ctx      r_ctx1, r_ctx2, r_ctx3, r_ctx4;
    logic [WV-1:0]      r_gr;
    logic               r_ovf2, r_ovf3, r_ovf4;
    logic signed [63:0] r_tbp, r_tep;
    logic signed [31:0] r_tb, r_te;

    logic [WV:0]        gsat;
    logic [32:0]        tbs, tes;
    logic signed [33:0] dp;
    upf_pkg::t_pot      n_pot;

    always_comb begin
        gsat = upf_pkg::sat_u31(r_gp);
        tbs  = upf_pkg::sat_s32_shr(r_tbp);
        tes  = upf_pkg::sat_s32_shr(r_tep);
        dp   = 34'(r_ctx4.pressure_begin) - 34'(r_tb)
             - 34'(r_ctx4.pressure_end) + 34'(r_te);
        n_pot.none     = r_ctx4.presence == 2'b00;
        n_pot.up_end   = dp[33];
        n_pot.live     = dp[33] ? r_ctx4.presence[1] : r_ctx4.presence[0];
        n_pot.rho      = r_rho4;
        n_pot.dp       = dp;
        n_pot.mob_up   = dp[33] ? r_ctx4.mobility_end : r_ctx4.mobility_begin;
        n_pot.coef     = r_ctx4.coef;
        n_pot.coef_ovf = r_ctx4.coef_ovf;
        n_pot.ovf      = r_ovf4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            o_valid <= r_v4;
        end
        // gravity times density
        r_gp   <= WP'(i_gravity) * WP'(i_rho);
        r_rho1 <= i_rho;
        r_ctx1 <= i_ctx;
        r_gr   <= gsat[WV-1:0];
        r_ovf2 <= gsat[WV];
        r_rho2 <= r_rho1;
        r_ctx2 <= r_ctx1;
        // gravity head at both ends
        r_tbp  <= 64'($signed({1'b0, r_gr})) * 64'(r_ctx2.depth_begin);
        r_tep  <= 64'($signed({1'b0, r_gr})) * 64'(r_ctx2.depth_end);
        r_ovf3 <= r_ovf2;
        r_rho3 <= r_rho2;
        r_ctx3 <= r_ctx2;
        r_tb   <= tbs[31:0];
        r_te   <= tes[31:0];
        r_ovf4 <= r_ovf3 | tbs[32] | tes[32];
        r_rho4 <= r_rho3;
        r_ctx4 <= r_ctx3;
        o_pot  <= n_pot;
    end

endmodule
`default_nettype wire

/* src/upf_flux.sv */
`timescale 1ns / 1ps
`default_nettype none
module upf_flux (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire upf_pkg::t_pot i_pot,
    output logic               o_valid,
    output upf_pkg::t_out_item o_item
);

    localparam int WV = upf_pkg::W_VAL;
    localparam int WP = upf_pkg::W_PROD;

    logic r_v1, r_v2, r_v3;
    logic [WP-1:0]      r_cp;
    logic signed [31:0] r_dps1, r_dps2;
    logic               r_xovf1, r_xovf2, r_xovf3;
    upf_pkg::t_pot      r_pot1, r_pot2, r_pot3;
    logic [WV-1:0]      r_c;
    logic signed [63:0] r_fp;

    logic               dp_ok;
    logic signed [31:0] n_dps;
    logic [WV:0]        csat;
    logic [32:0]        fsat;
    upf_pkg::t_out_item n_item;

    always_comb begin
        dp_ok = (&i_pot.dp[33:31]) | (~|i_pot.dp[33:31]);
        n_dps = dp_ok ? i_pot.dp[31:0] : (i_pot.dp[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        csat  = upf_pkg::sat_u31(r_cp);
        fsat  = upf_pkg::sat_s32_shr(r_fp);
        if (r_pot3.none) begin
            n_item = '0;
        end else begin
            n_item.upwind_is_end = r_pot3.up_end;
            n_item.mixed_density = r_pot3.rho;
            n_item.phase_flux    = r_pot3.live ? fsat[31:0] : '0;
            n_item.flux_valid    = r_pot3.live;
            n_item.overflow      = r_pot3.ovf | (r_pot3.live & (r_xovf3 | fsat[32]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            o_valid <= r_v3;
        end
        r_cp    <= WP'(i_pot.coef) * WP'(i_pot.mob_up);
        r_dps1  <= n_dps;
        r_xovf1 <= i_pot.coef_ovf | ~dp_ok;
        r_pot1  <= i_pot;
        r_c     <= csat[WV-1:0];
        r_dps2  <= r_dps1;
        r_xovf2 <= r_xovf1 | csat[WV];
        r_pot2  <= r_pot1;
        r_fp    <= 64'($signed({1'b0, r_c})) * 64'(r_dps2);
        r_xovf3 <= r_xovf2;
        r_pot3  <= r_pot2;
        o_item  <= n_item;
    end

endmodule
`default_nettype wire
